// ===== hw/rtl/aawl_pkg.sv =====
// ----------------------------------------------------------------------------
// Antialiased wide line expander package
// Field widths, fixed-point formats and shared types for the line expander.
// ----------------------------------------------------------------------------
package aawl_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS = 8;
	localparam int WIDTH_BITS = 16;

	localparam int RAD_W = 18;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int MAG_W = 30;
	localparam int SQ_W = 2 * MAG_W;
	localparam int L2_W = 62;
	localparam int ROOT_W = 31;
	localparam int QUO_W = 32;
	localparam int UNIT_W = 32;
	localparam int PROD_W = UNIT_W + RAD_W + 1;
	localparam int ACC_W = 64;
	localparam int SH_W = 2;

	localparam int STEPS_PER_CYCLE = 4;
	localparam int ITER_CYCLES = 8;
	localparam int ITER_CNT_W = 3;
	localparam logic [ITER_CNT_W-1:0] ITER_LAST = ITER_CNT_W'(ITER_CYCLES - 2);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [WIDTH_BITS-1:0]        line_width;
	} line_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         vertex_alpha;
		logic [2:0]                   vertex_slot;
		logic                         degenerate;
		logic                         last_vertex;
	} vertex_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [RAD_W-1:0]             w2;
		logic [RAD_W-1:0]             cr;
		logic                         degen;
		logic                         neg_x;
		logic                         neg_y;
	} line_ctx_t;

endpackage

// ===== hw/rtl/aa_wide_line_quad_expander_unit.sv =====
// ----------------------------------------------------------------------------
// Antialiased wide line quad expander
// The first vertex leaves after its line's transaction has passed the pipeline
// stages and the output register; the other seven follow one per cycle when the
// output is not stalled. Throughput is set by the square root unit, the
// dividers and the vertex emitter, each of which works on one line at a time.
// Asynchronous active-low reset empties every stage; no vertex is pending.
// ----------------------------------------------------------------------------
module aa_wide_line_quad_expander_unit
	import aawl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         line_valid,
	output logic         line_ready,
	input  line_item_t   line_data,
	output logic         vert_valid,
	input  logic         vert_ready,
	output vertex_item_t vert_data
);

	localparam int ROUND_SH = 31;
	localparam int Q_W = ACC_W - ROUND_SH + 1;
	localparam logic [ACC_W-1:0] RND_BIAS =
		(ACC_W'(1) << (ACC_W - 2)) + (ACC_W'(1) << (ROUND_SH - 1));
	localparam logic signed [Q_W-1:0] Q_OFFSET = Q_W'(ACC_W'(1) << ROUND_SH);
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((ACC_W'(1) << (COORD_BITS - 1)) - 1);
	localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [RAD_W-1:0] CR_QUARTER = RAD_W'(1) << (FRAC_BITS - 1);
	localparam logic [RAD_W-1:0] CR_3QUARTER = RAD_W'(3) << (FRAC_BITS - 1);
	localparam logic [RAD_W-1:0] CR_3HALF = RAD_W'(3) << FRAC_BITS;
	localparam logic [RAD_W-1:0] CR_SUB = RAD_W'(1) << (FRAC_BITS + 1);
	localparam logic [1:0] P_UCX = 2'd0;
	localparam logic [1:0] P_UCY = 2'd1;
	localparam logic [1:0] P_UWX = 2'd2;
	localparam logic [1:0] P_UWY = 2'd3;
	localparam int NORM_STEPS = 8;

	function automatic logic signed [COORD_BITS-1:0] round_sat(
		input logic signed [ACC_W-1:0] t
	);
		logic [ACC_W-1:0] u;
		logic signed [Q_W-1:0] q;
		u = ACC_W'(t) + RND_BIAS;
		q = $signed({1'b0, u[ACC_W-1:ROUND_SH]}) - Q_OFFSET;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return COORD_BITS'(q);
	endfunction

	// Stage valid bits and handoff strobes.
	logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld8_q, vld9_q;
	logic load1, load2, load3, load4, load5, load6, load7, load8;
	logic done3, done4, done5, done6, done7, release8, adv8, t_free, out_free;

	// Stage 1: differences and radii.
	line_ctx_t ctx_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [WIDTH_BITS-1:0] wk;
	logic [RAD_W-1:0] w2_d, cr_d;

	// Stage 2: magnitudes brought below 2^30.
	line_ctx_t ctx_s2;
	logic [MAG_W-1:0] ax_s2, ay_s2;
	logic [DIFF_W-1:0] mag_x, mag_y, mag_or;
	logic [SH_W-1:0] sh;

	// Stage 3: squares on one multiplier.
	line_ctx_t ctx_s3;
	logic [MAG_W-1:0] ax_s3, ay_s3, sq_op;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, sq;
	logic ph3_q;

	// Stage 4: normalize the squared length into [2^60, 2^62).
	line_ctx_t ctx_s4;
	logic [L2_W-1:0] l2_s4, l2_n;
	logic [ROOT_W-1:0] ax_s4, ay_s4, an_x, an_y;

	// Stage 5: square root.
	line_ctx_t ctx_s5;
	logic [ROOT_W-1:0] ax_s5, ay_s5, root;
	logic sqrt_busy;

	// Stage 6: unit vector division.
	line_ctx_t ctx_s6;
	logic [QUO_W-1:0] qx, qy;
	logic divx_busy, divy_busy;

	// Stage 7: offset products.
	line_ctx_t ctx_s7;
	logic signed [UNIT_W-1:0] ux_s7, uy_s7, mul_u;
	logic [RAD_W-1:0] mul_r;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s7 [4];
	logic [1:0] mph_q;
	logic mbusy_q;

	// Stage 8: vertex emitter.
	logic signed [ACC_W-1:0] sx_s8, sy_s8, ex_s8, ey_s8;
	logic signed [PROD_W-1:0] prod_s8 [4];
	logic degen_s8;
	logic [2:0] slot_s8;
	logic use_w2, plus;
	logic signed [ACC_W-1:0] off_x, off_y, bx, by, tx, ty;

	// Stage 9 and output register.
	logic signed [ACC_W-1:0] tx_s9, ty_s9;
	logic [2:0] slot_s9;
	logic degen_s9;
	vertex_item_t vert_q;
	logic vert_valid_q;

	// Handshake chain, back to front.
	always_comb begin
		out_free = !vert_valid_q || vert_ready;
		t_free = !vld9_q || out_free;
		adv8 = vld8_q && t_free;
		release8 = adv8 && (slot_s8 == 3'd7);
		done7 = vld7_q && !mbusy_q;
		load8 = done7 && (!vld8_q || release8);
		done6 = vld6_q && !divx_busy && !divy_busy;
		load7 = done6 && (!vld7_q || load8);
		done5 = vld5_q && !sqrt_busy;
		load6 = done5 && (!vld6_q || load7);
		done4 = vld4_q && (ctx_s4.degen || (l2_s4[L2_W-1 -: 2] != 2'b00));
		load5 = done4 && (!vld5_q || load6);
		done3 = vld3_q && !ph3_q;
		load4 = done3 && (!vld4_q || load5);
		load3 = vld2_q && (!vld3_q || load4);
		load2 = vld1_q && (!vld2_q || load3);
		line_ready = !vld1_q || load2;
		load1 = line_valid && line_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld1_q <= 1'b0;
			vld2_q <= 1'b0;
			vld3_q <= 1'b0;
			vld4_q <= 1'b0;
			vld5_q <= 1'b0;
			vld6_q <= 1'b0;
			vld7_q <= 1'b0;
			vld8_q <= 1'b0;
		end else begin
			vld1_q <= load1 || (vld1_q && !load2);
			vld2_q <= load2 || (vld2_q && !load3);
			vld3_q <= load3 || (vld3_q && !load4);
			vld4_q <= load4 || (vld4_q && !load5);
			vld5_q <= load5 || (vld5_q && !load6);
			vld6_q <= load6 || (vld6_q && !load7);
			vld7_q <= load7 || (vld7_q && !load8);
			vld8_q <= load8 || (vld8_q && !release8);
		end
	end

	// Stage 1.
	always_comb begin
		wk = line_data.line_width >> FRAC_BITS;
		w2_d = RAD_W'(line_data.line_width);
		priority if (wk < WIDTH_BITS'(2)) begin
			w2_d = RAD_W'(line_data.line_width) + CR_QUARTER;
			cr_d = CR_QUARTER;
		end else if (wk == WIDTH_BITS'(2)) begin
			cr_d = CR_3QUARTER;
		end else if (wk == WIDTH_BITS'(3)) begin
			cr_d = CR_3HALF;
		end else begin
			cr_d = RAD_W'(line_data.line_width) - CR_SUB;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			ctx_s1.start_x <= line_data.start_x;
			ctx_s1.start_y <= line_data.start_y;
			ctx_s1.end_x <= line_data.end_x;
			ctx_s1.end_y <= line_data.end_y;
			ctx_s1.w2 <= w2_d;
			ctx_s1.cr <= cr_d;
			ctx_s1.degen <= 1'b0;
			ctx_s1.neg_x <= 1'b0;
			ctx_s1.neg_y <= 1'b0;
			dx_s1 <= DIFF_W'(line_data.end_x) - DIFF_W'(line_data.start_x);
			dy_s1 <= DIFF_W'(line_data.end_y) - DIFF_W'(line_data.start_y);
		end
	end

	// Stage 2.
	always_comb begin
		mag_x = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		mag_y = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		mag_or = mag_x | mag_y;
		sh = '0;
		for (int i = MAG_W; i < DIFF_W; i++) begin
			if (mag_or[i]) begin
				sh = SH_W'(i - MAG_W + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			ctx_s2.start_x <= ctx_s1.start_x;
			ctx_s2.start_y <= ctx_s1.start_y;
			ctx_s2.end_x <= ctx_s1.end_x;
			ctx_s2.end_y <= ctx_s1.end_y;
			ctx_s2.w2 <= ctx_s1.w2;
			ctx_s2.cr <= ctx_s1.cr;
			ctx_s2.degen <= (dx_s1 == '0) && (dy_s1 == '0);
			ctx_s2.neg_x <= dx_s1[DIFF_W-1];
			ctx_s2.neg_y <= dy_s1[DIFF_W-1];
			ax_s2 <= MAG_W'(mag_x >> sh);
			ay_s2 <= MAG_W'(mag_y >> sh);
		end
	end

	// Stage 3.
	assign sq_op = ph3_q ? ay_s3 : ax_s2;
	assign sq = SQ_W'(sq_op) * SQ_W'(sq_op);

	always_ff @(posedge clk) begin
		if (load3) begin
			ctx_s3 <= ctx_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			sqx_s3 <= sq;
		end else if (ph3_q) begin
			sqy_s3 <= sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph3_q <= 1'b0;
		end else begin
			ph3_q <= load3;
		end
	end

	// Stage 4.
	always_comb begin
		l2_n = l2_s4;
		an_x = ax_s4;
		an_y = ay_s4;
		for (int j = 0; j < NORM_STEPS; j++) begin
			if (l2_n[L2_W-1 -: 2] == 2'b00) begin
				l2_n = l2_n << 2;
				an_x = an_x << 1;
				an_y = an_y << 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load4) begin
			ctx_s4 <= ctx_s3;
			l2_s4 <= L2_W'(sqx_s3) + L2_W'(sqy_s3);
			ax_s4 <= ROOT_W'(ax_s3);
			ay_s4 <= ROOT_W'(ay_s3);
		end else if (vld4_q && !done4) begin
			l2_s4 <= l2_n;
			ax_s4 <= an_x;
			ay_s4 <= an_y;
		end
	end

	// Stage 5.
	aawl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load5),
		.radicand (l2_s4),
		.busy     (sqrt_busy),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (load5) begin
			ctx_s5 <= ctx_s4;
			ax_s5 <= ax_s4;
			ay_s5 <= ay_s4;
		end
	end

	// Stage 6.
	aawl_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load6),
		.dividend (ax_s5),
		.divisor  (root),
		.busy     (divx_busy),
		.quotient (qx)
	);

	aawl_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load6),
		.dividend (ay_s5),
		.divisor  (root),
		.busy     (divy_busy),
		.quotient (qy)
	);

	always_ff @(posedge clk) begin
		if (load6) begin
			ctx_s6 <= ctx_s5;
		end
	end

	// Stage 7: the phase picks the component and the radius.
	assign mul_u = mph_q[0] ? uy_s7 : ux_s7;
	assign mul_r = mph_q[1] ? ctx_s7.w2 : ctx_s7.cr;
	assign prod = PROD_W'(mul_u) * PROD_W'($signed({1'b0, mul_r}));

	always_ff @(posedge clk) begin
		if (load7) begin
			ctx_s7 <= ctx_s6;
			if (ctx_s6.degen) begin
				ux_s7 <= '0;
				uy_s7 <= '0;
			end else begin
				ux_s7 <= ctx_s6.neg_x ? -$signed(UNIT_W'(qx)) : $signed(UNIT_W'(qx));
				uy_s7 <= ctx_s6.neg_y ? -$signed(UNIT_W'(qy)) : $signed(UNIT_W'(qy));
			end
		end else if (mbusy_q) begin
			prod_s7[mph_q] <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mph_q <= '0;
		end else if (load7) begin
			mbusy_q <= 1'b1;
			mph_q <= '0;
		end else if (mbusy_q) begin
			mph_q <= mph_q + 1'b1;
			mbusy_q <= (mph_q != P_UWY);
		end
	end

	// Stage 8.
	always_comb begin
		use_w2 = (slot_s8[2] == slot_s8[1]);
		plus = slot_s8[2];
		off_x = ACC_W'(use_w2 ? prod_s8[P_UWY] : prod_s8[P_UCY]);
		off_y = ACC_W'(use_w2 ? prod_s8[P_UWX] : prod_s8[P_UCX]);
		bx = slot_s8[0] ? ex_s8 : sx_s8;
		by = slot_s8[0] ? ey_s8 : sy_s8;
		tx = plus ? bx + off_x : bx - off_x;
		ty = plus ? by - off_y : by + off_y;
	end

	always_ff @(posedge clk) begin
		if (load8) begin
			sx_s8 <= (ACC_W'(ctx_s7.start_x) <<< ROUND_SH) - ACC_W'(prod_s7[P_UCX]);
			sy_s8 <= (ACC_W'(ctx_s7.start_y) <<< ROUND_SH) - ACC_W'(prod_s7[P_UCY]);
			ex_s8 <= (ACC_W'(ctx_s7.end_x) <<< ROUND_SH) + ACC_W'(prod_s7[P_UCX]);
			ey_s8 <= (ACC_W'(ctx_s7.end_y) <<< ROUND_SH) + ACC_W'(prod_s7[P_UCY]);
			prod_s8 <= prod_s7;
			degen_s8 <= ctx_s7.degen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s8 <= '0;
		end else if (load8) begin
			slot_s8 <= '0;
		end else if (adv8) begin
			slot_s8 <= slot_s8 + 1'b1;
		end
	end

	// Stage 9 and output register.
	always_ff @(posedge clk) begin
		if (adv8) begin
			tx_s9 <= tx;
			ty_s9 <= ty;
			slot_s9 <= slot_s8;
			degen_s9 <= degen_s8;
		end
		if (vld9_q && out_free) begin
			vert_q.vertex_x <= round_sat(tx_s9);
			vert_q.vertex_y <= round_sat(ty_s9);
			vert_q.vertex_alpha <= slot_s9[2] ^ slot_s9[1];
			vert_q.vertex_slot <= slot_s9;
			vert_q.degenerate <= degen_s9;
			vert_q.last_vertex <= (slot_s9 == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld9_q <= 1'b0;
			vert_valid_q <= 1'b0;
		end else begin
			if (t_free) begin
				vld9_q <= adv8;
			end
			if (out_free) begin
				vert_valid_q <= vld9_q;
			end
		end
	end

	assign vert_valid = vert_valid_q;
	assign vert_data = vert_q;

endmodule

// ===== hw/rtl/aawl_isqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 62-bit radicand, four result bits per cycle.
// ----------------------------------------------------------------------------
module aawl_isqrt
	import aawl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [L2_W-1:0]   radicand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	logic [ACC_W-1:0] rem_q, res_q, bit_q;
	logic [ACC_W-1:0] rem_d, res_d, bit_d;
	logic [ITER_CNT_W-1:0] cnt_q;
	logic busy_q;

	always_comb begin
		rem_d = load ? ACC_W'(radicand) : rem_q;
		res_d = load ? '0 : res_q;
		bit_d = load ? (ACC_W'(1) << (2 * ROOT_W)) : bit_q;
		for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
			if (rem_d >= res_d + bit_d) begin
				rem_d = rem_d - (res_d + bit_d);
				res_d = (res_d >> 1) + bit_d;
			end else begin
				res_d = res_d >> 1;
			end
			bit_d = bit_d >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (load || busy_q) begin
			rem_q <= rem_d;
			res_q <= res_d;
			bit_q <= bit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			busy_q <= (cnt_q != ITER_LAST);
		end
	end

	assign busy = busy_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

// ===== hw/rtl/aawl_div.sv =====
// ----------------------------------------------------------------------------
// Iterative unit-vector divider
// Restoring division of (dividend * 2^30) by the root, four quotient bits per
// cycle.
// ----------------------------------------------------------------------------
module aawl_div
	import aawl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [ROOT_W-1:0] dividend,
	input  logic [ROOT_W-1:0] divisor,
	output logic              busy,
	output logic [QUO_W-1:0]  quotient
);

	logic [QUO_W-1:0] rem_q, num_q, quo_q;
	logic [ROOT_W-1:0] den_q;
	logic [QUO_W-1:0] rem_d, num_d, quo_d;
	logic [ROOT_W-1:0] den_d;
	logic [QUO_W:0] trial;
	logic [ITER_CNT_W-1:0] cnt_q;
	logic busy_q;

	always_comb begin
		rem_d = load ? QUO_W'(dividend >> 2) : rem_q;
		num_d = load ? (QUO_W'(dividend[1:0]) << (QUO_W - 2)) : num_q;
		den_d = load ? divisor : den_q;
		quo_d = load ? '0 : quo_q;
		trial = '0;
		for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
			trial = {rem_d, num_d[QUO_W-1]};
			num_d = num_d << 1;
			if (trial >= (QUO_W + 1)'(den_d)) begin
				rem_d = QUO_W'(trial - (QUO_W + 1)'(den_d));
				quo_d = {quo_d[QUO_W-2:0], 1'b1};
			end else begin
				rem_d = QUO_W'(trial);
				quo_d = {quo_d[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load || busy_q) begin
			rem_q <= rem_d;
			num_q <= num_d;
			den_q <= den_d;
			quo_q <= quo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			busy_q <= (cnt_q != ITER_LAST);
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wide line quad expander testbench
// Sends line segments through the valid/ready input, predicts the eight strip
// vertices of each line in fixed point, and checks every output transaction.
// ----------------------------------------------------------------------------
module testbench;
	import aawl_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic line_valid = 1'b0;
	logic line_ready;
	line_item_t line_data = '0;
	logic vert_valid;
	logic vert_ready = 1'b0;
	vertex_item_t vert_data;

	vertex_item_t vertex_queue[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit hold_output = 1'b0;
	bit free_output = 1'b0;

	aa_wide_line_quad_expander_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(line_valid),
		.line_ready(line_ready),
		.line_data(line_data),
		.vert_valid(vert_valid),
		.vert_ready(vert_ready),
		.vert_data(vert_data)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] round_sat(longint t);
		longint q;
		longint hi;
		hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
		q = (t + (64'sd1 <<< 30)) >>> 31;
		if (q > hi) q = hi;
		if (q < -hi - 1) q = -hi - 1;
		return q[COORD_BITS-1:0];
	endfunction

	task automatic predict_vertices(line_item_t li);
		longint x1, y1, x2, y2, dx, dy, w, k, w2, cr;
		longint ux, uy, nx, ny, sx, sy, ex, ey, r, sg, bx, by;
		logic [63:0] ax, ay, l2, s, mx, my;
		int m;
		bit degen;
		vertex_item_t v;
		x1 = li.start_x;
		y1 = li.start_y;
		x2 = li.end_x;
		y2 = li.end_y;
		w = li.line_width;
		k = w >> FRAC_BITS;
		dx = x2 - x1;
		dy = y2 - y1;
		degen = (dx == 0 && dy == 0);
		ux = 0;
		uy = 0;
		if (k < 2) begin
			w2 = w + (1 << (FRAC_BITS - 1));
			cr = 1 << (FRAC_BITS - 1);
		end else if (k == 2) begin
			w2 = w;
			cr = 3 << (FRAC_BITS - 1);
		end else if (k == 3) begin
			w2 = w;
			cr = 3 << FRAC_BITS;
		end else begin
			w2 = w;
			cr = w - (1 << (FRAC_BITS + 1));
		end
		if (!degen) begin
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			m = 0;
			while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
				ax = ax >> 1;
				ay = ay >> 1;
			end
			l2 = ax * ax + ay * ay;
			while (l2 < (64'd1 << 60)) begin
				l2 = l2 << 2;
				m++;
			end
			s = isqrt(l2);
			mx = ((ax << m) << 30) / s;
			my = ((ay << m) << 30) / s;
			ux = dx < 0 ? -longint'(mx) : longint'(mx);
			uy = dy < 0 ? -longint'(my) : longint'(my);
		end
		nx = uy;
		ny = -ux;
		sx = x1 * (64'sd1 <<< 31) - ux * cr;
		sy = y1 * (64'sd1 <<< 31) - uy * cr;
		ex = x2 * (64'sd1 <<< 31) + ux * cr;
		ey = y2 * (64'sd1 <<< 31) + uy * cr;
		for (int i = 0; i < 8; i++) begin
			r = (i == 0 || i == 1 || i == 6 || i == 7) ? w2 : cr;
			sg = (i < 4) ? -1 : 1;
			bx = (i & 1) ? ex : sx;
			by = (i & 1) ? ey : sy;
			v.vertex_x = round_sat(bx + sg * nx * r);
			v.vertex_y = round_sat(by + sg * ny * r);
			v.vertex_alpha = (i >= 2 && i <= 5);
			v.vertex_slot = i[2:0];
			v.degenerate = degen;
			v.last_vertex = (i == 7);
			vertex_queue.push_back(v);
		end
	endtask

	function automatic int random_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
		return $urandom_range(0, 3);
	endfunction

	// Valid stays high across back-to-back transactions; it drops only for a gap.
	task automatic send_line(line_item_t li);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			line_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		line_data <= li;
		line_valid <= 1'b1;
		@(posedge clk);
		while (!line_ready) @(posedge clk);
		predict_vertices(li);
		@(negedge clk);
	endtask

	task automatic send_coords(longint sx, longint sy, longint ex, longint ey, int w);
		line_item_t li;
		li.start_x = sx[COORD_BITS-1:0];
		li.start_y = sy[COORD_BITS-1:0];
		li.end_x = ex[COORD_BITS-1:0];
		li.end_y = ey[COORD_BITS-1:0];
		li.line_width = w[WIDTH_BITS-1:0];
		send_line(li);
	endtask

	// Output side: random stalls, a forced long stall, or always ready.
	always @(negedge clk) begin
		if (hold_output) vert_ready <= 1'b0;
		else if (free_output) vert_ready <= 1'b1;
		else vert_ready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
			($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		vertex_item_t exp_v;
		if (arst_n && vert_valid && vert_ready) begin
			if (vertex_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected vertex transaction: %p", vert_data);
			end else begin
				exp_v = vertex_queue.pop_front();
				if (vert_data !== exp_v) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Vertex mismatch: expected %p, actual %p", exp_v, vert_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((line_valid && line_ready) || (vert_valid && vert_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_width_classes();
		int widths[10] = '{0, 1, 255, 256, 511, 512, 767, 768, 1024, 65535};
		foreach (widths[i]) send_coords(0, 0, 2560, 1280, widths[i]);
	endtask

	task automatic test_extremes();
		longint mx, mn;
		mx = (64'sd1 <<< (COORD_BITS - 1)) - 1;
		mn = -mx - 1;
		send_coords(mn, mn, mx, mx, 65535);
		send_coords(mx, mx, mn, mn, 1024);
		send_coords(mx, mn, mn, mx, 512);
		send_coords(mx, 0, mx, 1, 300);
		send_coords(mn, 0, mn, 0, 65535);
		send_coords(0, 0, 1, 0, 0);
		send_coords(0, 0, 0, -1, 768);
		send_coords(-100, -100, 3, 5, 256);
	endtask

	task automatic test_degenerate();
		send_coords(1000, -2000, 1000, -2000, 512);
		send_coords(0, 0, 0, 0, 0);
		send_coords(-5, 7, -5, 7, 2048);
	endtask

	task automatic test_random_lines();
		longint ax, ay, bx, by;
		int w;
		for (int n = 0; n < 67; n++) begin
			ax = $signed($urandom_range(0, 2 ** COORD_BITS - 1) - 2 ** (COORD_BITS - 1));
			ay = $signed($urandom_range(0, 2 ** COORD_BITS - 1) - 2 ** (COORD_BITS - 1));
			case ($urandom_range(0, 3))
				0: begin
					bx = ax + $signed($urandom_range(0, 64)) - 32;
					by = ay + $signed($urandom_range(0, 64)) - 32;
				end
				1: begin
					bx = ax;
					by = ay;
				end
				default: begin
					bx = $signed($urandom_range(0, 2 ** COORD_BITS - 1) - 2 ** (COORD_BITS - 1));
					by = $signed($urandom_range(0, 2 ** COORD_BITS - 1) - 2 ** (COORD_BITS - 1));
				end
			endcase
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2047);
			send_coords(ax, ay, bx, by, w);
		end
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				hold_output = 1'b1;
				repeat (300) @(posedge clk);
				hold_output = 1'b0;
			end
			for (int n = 0; n < 12; n++)
				send_coords($urandom_range(0, 100000), $urandom_range(0, 100000),
					$urandom_range(0, 100000), $urandom_range(0, 100000),
					$urandom_range(0, 3000));
		join
	endtask

	task automatic test_full_rate();
		logic [127:0] raw;
		free_output = 1'b1;
		for (int n = 0; n < 10; n++) begin
			raw = {$urandom, $urandom, $urandom, $urandom};
			line_data <= raw[$bits(line_item_t)-1:0];
			line_valid <= 1'b1;
			@(posedge clk);
			while (!line_ready) @(posedge clk);
			predict_vertices(line_data);
			@(negedge clk);
		end
		line_valid <= 1'b0;
		free_output = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_width_classes();
		test_extremes();
		test_degenerate();
		test_random_lines();
		test_output_backpressure();
		test_full_rate();
		while (vertex_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
